// File: src/md5_pkg.sv
// Shared types, constants and step functions for the MD5 digest block.
package md5_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] LAST_SLOT = 6'h3F;
	localparam logic [5:0] LAST_STEP = 6'h3F;
	localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	typedef logic [15:0][31:0] md5_words_t;

	typedef struct packed {
		md5_words_t words;
		logic       last;
	} md5_blk_t;

	function automatic logic [31:0] step_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] step_shift(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word used by each step; the multiplies wrap at four bits.
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] k;
		logic [3:0] g;
		k = i[3:0];
		case (i[5:4])
			2'd0: g = k;
			2'd1: g = (k << 2) + k + 4'd1;
			2'd2: g = (k << 1) + k + 4'd5;
			2'd3: g = (k << 3) - k;
			default: g = k;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] d;
		d = {v, v} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] byte_swap(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// File: src/md5_front.sv
// Byte collector: assembles message bytes into blocks and inserts the padding.
module md5_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              has_byte,
	input  logic              is_last,
	output logic              blk_push,
	output md5_pkg::md5_blk_t blk,
	input  logic              blk_full
);
	import md5_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_PAD, F_LEN} front_state_t;

	front_state_t state_q;
	logic [503:0] sh_q;
	logic [5:0]   fill_q;
	logic [63:0]  bitlen_q;
	logic [2:0]   len_idx_q;
	logic         pad_first_q;

	logic         room;
	logic         accept;
	logic         emit;
	logic [7:0]   emit_val;
	logic [511:0] flat;
	md5_words_t   words_c;

	// The 64th byte of a block can only go in when the queue has space for it.
	assign room   = !(fill_q == LAST_SLOT && blk_full);
	assign full   = (state_q != F_IDLE) || !room;
	assign accept = push && !full;

	always_comb begin
		emit     = 1'b0;
		emit_val = data_byte;
		case (state_q)
			F_IDLE: begin
				emit     = accept && has_byte;
				emit_val = data_byte;
			end
			F_PAD: begin
				emit     = room;
				emit_val = pad_first_q ? PAD_BYTE : 8'h00;
			end
			F_LEN: begin
				emit     = room;
				emit_val = bitlen_q[{len_idx_q, 3'd0} +: 8];
			end
			default: begin
				emit     = 1'b0;
				emit_val = data_byte;
			end
		endcase
	end

	// Byte 0 of the block sits at the top of the shift line; words are little-endian.
	assign flat = {sh_q, emit_val};

	always_comb begin
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				words_c[w][8*b +: 8] = flat[511 - 8*(4*w + b) -: 8];
			end
		end
	end

	assign blk_push   = emit && (fill_q == LAST_SLOT);
	assign blk.words  = words_c;
	assign blk.last   = (state_q == F_LEN) && (len_idx_q == LAST_LEN_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			fill_q      <= '0;
			bitlen_q    <= '0;
			len_idx_q   <= '0;
			pad_first_q <= 1'b0;
		end else begin
			if (emit) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (has_byte) begin
							bitlen_q <= bitlen_q + BYTE_BITS;
						end
						if (is_last) begin
							state_q     <= F_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				F_PAD: begin
					if (emit) begin
						pad_first_q <= 1'b0;
						if (fill_q == LEN_START - 6'd1) begin
							state_q   <= F_LEN;
							len_idx_q <= '0;
						end
					end
				end
				F_LEN: begin
					if (emit) begin
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == LAST_LEN_BYTE) begin
							state_q  <= F_IDLE;
							bitlen_q <= '0;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sh_q <= {sh_q[495:0], emit_val};
		end
	end

endmodule

// File: src/md5_blkq.sv
// Short block queue between the byte collector and the compression core.
module md5_blkq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  md5_pkg::md5_blk_t wr_blk,
	output logic              full,
	input  logic              pop,
	output md5_pkg::md5_blk_t rd_blk,
	output logic              empty
);
	import md5_pkg::*;

	md5_blk_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full    = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_blk  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_blk;
		end
	end

endmodule

// File: src/md5_core.sv
// Compression core: one MD5 step per cycle, chaining words and the digest register.
module md5_core (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::md5_blk_t blk,
	input  logic              blk_empty,
	output logic              blk_pop,
	input  logic              pop,
	output logic              empty,
	output logic [63:0]       digest_high,
	output logic [63:0]       digest_low
);
	import md5_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FIN} core_state_t;

	core_state_t state_q;
	logic [5:0]  rnd_q;
	logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [31:0] kw_q;
	logic        out_valid_q;
	logic [63:0] dig_high_q;
	logic [63:0] dig_low_q;

	logic [5:0]  kw_idx;
	logic [31:0] kw_next;
	logic [31:0] f_c;
	logic [31:0] t_c;
	logic [31:0] nb_c;
	logic [31:0] sum_a, sum_b, sum_c, sum_d;
	logic        fin_go;

	// Constant plus message word is prepared one step ahead.
	assign kw_idx  = (state_q == C_IDLE) ? rnd_q : rnd_q + 6'd1;
	assign kw_next = step_const(kw_idx) + blk.words[msg_index(kw_idx)];

	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f_c = wd_q ^ (wb_q & (wc_q ^ wd_q));
			2'd1:    f_c = wc_q ^ (wd_q & (wb_q ^ wc_q));
			2'd2:    f_c = wb_q ^ wc_q ^ wd_q;
			2'd3:    f_c = wc_q ^ (wb_q | ~wd_q);
			default: f_c = '0;
		endcase
	end

	assign t_c  = wa_q + f_c + kw_q;
	assign nb_c = wb_q + rotl32(t_c, step_shift(rnd_q));

	assign sum_a = ch_a_q + wa_q;
	assign sum_b = ch_b_q + wb_q;
	assign sum_c = ch_c_q + wc_q;
	assign sum_d = ch_d_q + wd_q;

	// A final block waits until the digest register is free or being read.
	assign fin_go  = !(blk.last && out_valid_q && !pop);
	assign blk_pop = (state_q == C_FIN) && fin_go;

	assign empty       = !out_valid_q;
	assign digest_high = dig_high_q;
	assign digest_low  = dig_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			rnd_q       <= '0;
			ch_a_q      <= IV_A;
			ch_b_q      <= IV_B;
			ch_c_q      <= IV_C;
			ch_d_q      <= IV_D;
			out_valid_q <= 1'b0;
		end else begin
			// A new digest may replace the one being read in the same cycle.
			if (state_q == C_FIN && fin_go && blk.last) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				C_IDLE: begin
					if (!blk_empty) begin
						state_q <= C_ROUND;
						rnd_q   <= '0;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_STEP) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					if (fin_go) begin
						state_q <= C_IDLE;
						if (blk.last) begin
							ch_a_q      <= IV_A;
							ch_b_q      <= IV_B;
							ch_c_q      <= IV_C;
							ch_d_q      <= IV_D;
						end else begin
							ch_a_q <= sum_a;
							ch_b_q <= sum_b;
							ch_c_q <= sum_c;
							ch_d_q <= sum_d;
						end
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kw_q <= kw_next;
		if (state_q == C_IDLE) begin
			wa_q <= ch_a_q;
			wb_q <= ch_b_q;
			wc_q <= ch_c_q;
			wd_q <= ch_d_q;
		end else if (state_q == C_ROUND) begin
			wa_q <= wd_q;
			wd_q <= wc_q;
			wc_q <= wb_q;
			wb_q <= nb_c;
		end
		if (state_q == C_FIN && fin_go && blk.last) begin
			dig_high_q <= {byte_swap(sum_a), byte_swap(sum_b)};
			dig_low_q  <= {byte_swap(sum_c), byte_swap(sum_d)};
		end
	end

`ifndef SYNTH
	a_pop_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		blk_pop |-> !blk_empty)
		else $error("core released a block the queue does not hold");

	a_round_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_ROUND && rnd_q == LAST_STEP) |=> state_q == C_FIN)
		else $error("last step did not lead to the final add");

	a_idle_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_IDLE) |-> rnd_q == '0 || $past(state_q == C_FIN))
		else $error("step counter not cleared while idle");

	a_digest_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == C_FIN && blk.last))
		else $error("digest shown without a finished final block");
`endif

endmodule

// File: src/md5_message_digest.sv
// Top level of the MD5 digest block: byte collector, block queue and compression core.
// Message bytes enter one per cycle while the collector has room; every 64th byte hands
// a whole block to a two-entry queue, and the core loads each block while idle, runs the
// 64 steps at one per cycle and then does one chaining add, so a long message streams at
// a rate set by the single step unit. The closing request holds full high while the
// collector writes the padding and the 8 length bytes one per cycle while the queue has
// room; the digest appears on the result ports once the core finishes the final block,
// and the next message may be pushed as soon as the length bytes are written. No clearing
// pass follows reset.
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	input  logic        pop,
	output logic        empty,
	output logic [63:0] digest_high,
	output logic [63:0] digest_low
);
	import md5_pkg::*;

	md5_blk_t wr_blk;
	md5_blk_t rd_blk;
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;

	md5_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.is_last   (is_last),
		.blk_push  (q_push),
		.blk       (wr_blk),
		.blk_full  (q_full)
	);

	md5_blkq u_blkq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_blk (wr_blk),
		.full   (q_full),
		.pop    (q_pop),
		.rd_blk (rd_blk),
		.empty  (q_empty)
	);

	md5_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.blk         (rd_blk),
		.blk_empty   (q_empty),
		.blk_pop     (q_pop),
		.pop         (pop),
		.empty       (empty),
		.digest_high (digest_high),
		.digest_low  (digest_low)
	);

endmodule
